/* hdl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character map for the base64url decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  // Saturation limit of the decoded byte count
  localparam int unsigned MAX_DECODED_BYTES = 49152;
  localparam int unsigned COUNT_W           = 16;
  localparam int unsigned COUNT_MAX_RAW     = (1 << COUNT_W) - 1;
  localparam int unsigned COUNT_LIMIT_INT   =
    (MAX_DECODED_BYTES > COUNT_MAX_RAW) ? COUNT_MAX_RAW : MAX_DECODED_BYTES;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_LIMIT_INT[COUNT_W-1:0];

  // Queue between the front and the back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Character classes
  typedef enum logic [1:0] {
    KIND_SEXTET = 2'd0,
    KIND_PAD    = 2'd1,
    KIND_BAD    = 2'd2
  } char_kind_t;

  // Quartet positions
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  // One classified character as it moves through the queue
  typedef struct packed {
    char_kind_t  kind;
    logic [5:0]  sextet;
    logic        last;
  } b64d_item_t;

  // Queue handshake toward the back
  typedef struct packed {
    logic       valid;
    b64d_item_t item;
  } b64d_head_t;

  // Map one character of the URL-safe alphabet
  function automatic b64d_item_t classify(input logic [7:0] ch, input logic last);
    b64d_item_t it;
    logic [7:0] val;
    begin
      it.kind   = KIND_SEXTET;
      it.last   = last;
      val       = 8'd0;
      if (ch inside {[8'h41:8'h5A]}) begin
        val = ch - 8'h41;
      end else if (ch inside {[8'h61:8'h7A]}) begin
        val = ch - 8'h61 + 8'd26;
      end else if (ch inside {[8'h30:8'h39]}) begin
        val = ch - 8'h30 + 8'd52;
      end else if (ch == 8'h2D) begin
        val = 8'd62;
      end else if (ch == 8'h5F) begin
        val = 8'd63;
      end else if (ch == 8'h3D) begin
        it.kind = KIND_PAD;
      end else begin
        it.kind = KIND_BAD;
      end
      it.sextet = val[5:0];
      return it;
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/base64url_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// base64url_stream_decoder_top
// Streaming base64url decoder, one character per beat, padding optional.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one character per beat, with
//   in_is_final set on the last character of each string. Every input beat
//   yields exactly one result beat on out_valid/out_ready. out_byte_valid
//   flags a completed data byte. On the final beat out_done_res is set,
//   out_bad_input reports an invalid string (all its bytes are then to be
//   dropped) and out_decoded_count gives the saturating byte count.
//   A beat passes through the front register, a queue slot and the result
//   register on its way to the result beat. Throughput: one character per
//   cycle as long as the receiver holds out_ready high for every result beat.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the
//   quartet state; a new string starts at the first beat after reset.
//   When the receiver stalls, the result register holds, the two-entry
//   queue and the front register fill, and in_ready drops after that;
//   no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_char,
  input  wire logic        in_is_final,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_done_res,
  output logic             out_bad_input,
  output logic [15:0]      out_decoded_count,
  output logic             out_valid,
  input  wire logic        out_ready
);

  logic                 push;
  logic                 q_full;
  logic                 pop;
  b64d_pkg::b64d_item_t push_item;
  b64d_pkg::b64d_head_t head;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_char     (in_char),
    .in_is_final (in_is_final),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  b64d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_done_res      (out_done_res),
    .out_bad_input     (out_bad_input),
    .out_decoded_count (out_decoded_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

  // Non-final beats carry no verdict or count
  a_no_verdict_midstring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> !out_bad_input && out_decoded_count == 16'd0)
    else $error("verdict on a non-final beat");

  // A byte that is not valid reads as zero
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0)
    else $error("stray data byte");

  // Bad strings report no count
  a_bad_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_decoded_count == 16'd0)
    else $error("count on a bad string");

  // Count never passes the saturation limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_decoded_count <= b64d_pkg::COUNT_LIMIT)
    else $error("count above limit");

endmodule

`default_nettype wire

/* hdl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character beats, classifies them and holds one in a register
// until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_char,
  input  wire logic               in_is_final,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    push,
  output b64d_pkg::b64d_item_t    push_item,
  input  wire logic               q_full
);

  logic                 hold_valid_r;
  logic                 hold_valid_nxt;
  b64d_pkg::b64d_item_t hold_item_r;

  // Register drains whenever the queue has room
  assign push      = hold_valid_r && !q_full;
  assign push_item = hold_item_r;
  assign in_ready  = !hold_valid_r || !q_full;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Classified beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item_r <= b64d_pkg::classify(in_char, in_is_final);
    end
  end

endmodule

`default_nettype wire

/* hdl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO of classified characters between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire b64d_pkg::b64d_item_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output b64d_pkg::b64d_head_t      head
);

  b64d_pkg::b64d_item_t                 slot_r [b64d_pkg::Q_DEPTH];
  logic [b64d_pkg::Q_PTR_W-1:0]         wr_ptr_r;
  logic [b64d_pkg::Q_PTR_W-1:0]         rd_ptr_r;
  logic [b64d_pkg::Q_CNT_W-1:0]         count_r;
  logic [b64d_pkg::Q_CNT_W-1:0]         count_nxt;

  localparam logic [b64d_pkg::Q_CNT_W-1:0] DEPTH_CNT =
    b64d_pkg::Q_DEPTH[b64d_pkg::Q_CNT_W-1:0];
  localparam logic [b64d_pkg::Q_PTR_W-1:0] LAST_PTR =
    b64d_pkg::Q_PTR_W'(b64d_pkg::Q_DEPTH - 1);

  assign full       = (count_r == DEPTH_CNT);
  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Quartet decoder: tracks position, pad and error state, assembles bytes
// and drives the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire b64d_pkg::b64d_head_t head,
  output logic                      pop,
  output logic [7:0]                out_byte,
  output logic                      out_byte_valid,
  output logic                      out_done_res,
  output logic                      out_bad_input,
  output logic [15:0]               out_decoded_count,
  output logic                      out_valid,
  input  wire logic                 out_ready
);

  logic [1:0]                     pos_r,  pos_nxt;
  logic [5:0]                     held_r, held_nxt;
  logic                           pad_r,  pad_nxt;
  logic                           err_r,  err_nxt;
  logic [b64d_pkg::COUNT_W-1:0]   cnt_r,  cnt_nxt;

  logic                           ov_r;
  logic [7:0]                     byte_nxt;
  logic                           emit;
  logic                           err;
  logic                           bad;
  logic [b64d_pkg::COUNT_W-1:0]   cnt_step;
  logic [1:0]                     pos_step;
  b64d_pkg::b64d_item_t           it;

  logic [7:0]                     ob_r;
  logic                           obv_r, odone_r, obad_r;
  logic [15:0]                    ocnt_r;

  assign it  = head.item;
  assign pop = head.valid && (!ov_r || out_ready);

  // Decode step for the head item
  always_comb begin
    err      = 1'b0;
    emit     = 1'b0;
    byte_nxt = 8'd0;
    pad_nxt  = pad_r;
    held_nxt = held_r;
    if (pad_r) begin
      // only a second pad closing the quartet may follow a pad
      if (!(it.kind == b64d_pkg::KIND_PAD && pos_r == b64d_pkg::POS_FOURTH)) begin
        err = 1'b1;
      end
    end else if (it.kind == b64d_pkg::KIND_BAD) begin
      err = 1'b1;
    end else if (it.kind == b64d_pkg::KIND_PAD) begin
      if (pos_r == b64d_pkg::POS_FIRST || pos_r == b64d_pkg::POS_SECOND) begin
        err = 1'b1;
      end else begin
        pad_nxt = 1'b1;
      end
    end else begin
      case (pos_r)
        b64d_pkg::POS_FIRST: begin
          emit = 1'b0;
        end
        b64d_pkg::POS_SECOND: begin
          byte_nxt = {held_r, it.sextet[5:4]};
          emit     = 1'b1;
        end
        b64d_pkg::POS_THIRD: begin
          byte_nxt = {held_r[3:0], it.sextet[5:2]};
          emit     = 1'b1;
        end
        default: begin
          byte_nxt = {held_r[1:0], it.sextet};
          emit     = 1'b1;
        end
      endcase
      held_nxt = it.sextet;
    end

    err_nxt = err_r || err;
    if (err_nxt) begin
      emit     = 1'b0;
      byte_nxt = 8'd0;
    end

    pos_step = pos_r + 2'd1;
    cnt_step = (emit && (cnt_r < b64d_pkg::COUNT_LIMIT)) ? cnt_r + 1'b1 : cnt_r;
    bad      = err_nxt || (pos_step == b64d_pkg::POS_SECOND);

    pos_nxt = pos_step;
    cnt_nxt = cnt_step;
    // Final character closes the string and clears all state
    if (it.last) begin
      pos_nxt  = b64d_pkg::POS_FIRST;
      held_nxt = 6'd0;
      pad_nxt  = 1'b0;
      err_nxt  = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= b64d_pkg::POS_FIRST;
      held_r <= 6'd0;
      pad_r  <= 1'b0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (pop) begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      pad_r  <= pad_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (pop) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ob_r    <= byte_nxt;
      obv_r   <= emit;
      odone_r <= it.last;
      obad_r  <= it.last && bad;
      ocnt_r  <= (it.last && !bad) ? 16'(cnt_step) : 16'd0;
    end
  end

  assign out_valid         = ov_r;
  assign out_byte          = ob_r;
  assign out_byte_valid    = obv_r;
  assign out_done_res      = odone_r;
  assign out_bad_input     = obad_r;
  assign out_decoded_count = ocnt_r;

endmodule

`default_nettype wire
